### hdl/olpd_pkg.sv
// Shared types and constants for the ordered list core.
// No dependencies; imported by olpd_cell and the top level.
`default_nettype none
package olpd_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [2:0] {
      ACT_APPEND     = 3'd0,
      ACT_DEL_FIRST  = 3'd1,
      ACT_DEL_LAST   = 3'd2,
      ACT_DEL_AT     = 3'd3,
      ACT_READ_ALL   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_INVALID = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SHIFT  = 2'd2,
      CMD_ROTATE = 2'd3
   } cmd_type;

   // Broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      cmd_type            cmd;
      idx_type            idx;
      cnt_type            occ;
      logic signed [31:0] value;
      logic signed [31:0] head;
   } cell_ctrl_type;

endpackage
`default_nettype wire

### hdl/olpd_cell.sv
// One storage cell of the list chain.
// Depends on olpd_pkg for the broadcast control word.
`default_nettype none
module olpd_cell
   import olpd_pkg::*;
(
   input  wire logic               clock,
   input  wire cell_ctrl_type      ctrl,
   input  wire idx_type            cell_index,
   input  wire logic signed [31:0] upper_data,
   output logic signed [31:0]      data_out
);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;
   cnt_type            my_pos;
   cnt_type            next_pos;

   assign my_pos   = {1'b0, cell_index};
   assign next_pos = my_pos + cnt_type'(1);

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.cmd)
         CMD_HOLD: begin
            data_in = data_ff;
         end
         CMD_APPEND: begin
            if (my_pos == ctrl.occ) begin
               data_in = ctrl.value;
            end
         end
         CMD_SHIFT: begin
            // Cells from the removed one up to the one below the top occupied cell take their upper neighbor.
            if (cell_index >= ctrl.idx && next_pos < ctrl.occ) begin
               data_in = upper_data;
            end
         end
         CMD_ROTATE: begin
            if (next_pos < ctrl.occ) begin
               data_in = upper_data;
            end else if (next_pos == ctrl.occ) begin
               data_in = ctrl.head;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule
`default_nettype wire

### hdl/ordered_list_with_positional_delete_core.sv
// Ordered list of signed 32-bit words kept packed in a chain of cells.
// Append and each delete register their result at the edge that accepts the word; an
// unused action is consumed without one. One word per cycle goes through while results drain.
// Read-out of a non-empty list accepts the word, then sends one word per cycle from the head
// cell while the chain rotates and results drain; no new word is accepted meanwhile.
// An empty list gets a single EMPTY result. Reset (synchronous, active high) empties the list.
`default_nettype none
module ordered_list_with_positional_delete_core
   import olpd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_action,
   input  wire logic signed [31:0] req_value,
   input  wire logic [7:0]         req_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_item,
   output logic                    rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   cnt_type            occ_ff, occ_in;
   cnt_type            rd_cnt_ff, rd_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_item_ff, rsp_item_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_ctrl_type      ctrl;
   logic signed [31:0] cell_q [CAPACITY];
   logic               out_free;
   logic               accept;
   logic               emit;
   logic [7:0]         occ_wide;

   // The output register may be reloaded when it is empty or being taken.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign emit      = (state_ff == ST_READ) && out_free;
   assign occ_wide  = 8'(occ_ff);

   // Sequencer: decodes the accepted word into a chain command and its result, and steps the read-out.
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      rd_cnt_in     = rd_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl.cmd      = CMD_HOLD;
      ctrl.idx      = '0;
      ctrl.occ      = occ_ff;
      ctrl.value    = req_value;
      ctrl.head     = cell_q[0];

      if (accept) begin
         rsp_item_in = '0;
         rsp_last_in = 1'b1;
         unique case (req_action)
            ACT_APPEND: begin
               rsp_valid_in = 1'b1;
               if (occ_ff == cnt_type'(CAPACITY)) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  rsp_status_in = STAT_OK;
                  ctrl.cmd      = CMD_APPEND;
                  occ_in        = occ_ff + cnt_type'(1);
               end
            end
            ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DEL_AT: begin
               rsp_valid_in = 1'b1;
               if (req_action == ACT_DEL_FIRST) begin
                  ctrl.idx = '0;
               end else if (req_action == ACT_DEL_LAST) begin
                  ctrl.idx = idx_type'(occ_ff - cnt_type'(1));
               end else begin
                  ctrl.idx = idx_type'(req_position - 8'd1);
               end
               priority if (occ_ff == '0) begin
                  rsp_status_in = STAT_EMPTY;
               end else if (req_action == ACT_DEL_AT &&
                            (req_position == 8'd0 || req_position > occ_wide)) begin
                  rsp_status_in = STAT_INVALID;
               end else begin
                  rsp_status_in = STAT_OK;
                  rsp_item_in   = cell_q[ctrl.idx];
                  ctrl.cmd      = CMD_SHIFT;
                  occ_in        = occ_ff - cnt_type'(1);
               end
            end
            ACT_READ_ALL: begin
               if (occ_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  // Nothing is emitted yet; the read state streams the words.
                  state_in  = ST_READ;
                  rd_cnt_in = occ_ff;
               end
            end
            default: begin
               // Unused action codes are consumed without a result.
               rsp_item_in = rsp_item_ff;
               rsp_last_in = rsp_last_ff;
            end
         endcase
      end else if (emit) begin
         // The head word goes out while the occupied cells rotate by one.
         rsp_valid_in  = 1'b1;
         rsp_status_in = STAT_OK;
         rsp_item_in   = cell_q[0];
         rsp_last_in   = (rd_cnt_ff == cnt_type'(1));
         ctrl.cmd      = CMD_ROTATE;
         rd_cnt_in     = rd_cnt_ff - cnt_type'(1);
         if (rd_cnt_ff == cnt_type'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   // The chain: each cell sees its upper neighbor; the top cell sees itself.
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [31:0] upper;
         if (gi == CAPACITY - 1) begin : g_top
            assign upper = cell_q[gi];
         end else begin : g_mid
            assign upper = cell_q[gi + 1];
         end
         olpd_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .cell_index (idx_type'(gi)),
            .upper_data (upper),
            .data_out   (cell_q[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_last   = rsp_last_ff;

   // The count of stored words never passes the number of cells.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cnt_type'(CAPACITY))
      else $error("occupancy exceeds capacity");

   // A read-out always has words left to send and never more than are stored.
   a_rd_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rd_cnt_ff != '0 && rd_cnt_ff <= occ_ff))
      else $error("read-out counter out of range");

   // A successful append grows the list by exactly one word.
   a_append: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_APPEND && occ_ff != cnt_type'(CAPACITY))
      |=> (occ_ff == $past(occ_ff) + cnt_type'(1)))
      else $error("append did not grow the list");

   // The word flagged last of a read-out returns the sequencer to idle.
   a_read_end: assert property (@(posedge clock) disable iff (reset)
      (emit && rd_cnt_ff == cnt_type'(1)) |=> (state_ff == ST_IDLE && rsp_last_ff))
      else $error("read-out did not end on its last word");

endmodule
`default_nettype wire
